@@ hdl/stream_header_stripper_pcm_assert.svh @@
// Assertion macros for the stream header stripper.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef STREAM_HEADER_STRIPPER_PCM_ASSERT_SVH
`define STREAM_HEADER_STRIPPER_PCM_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SHSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SHSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/shsp_pkg.sv @@
// Package for the stream header stripper: phase and event codes, header constants
// and the status struct. Used by every module of the block.
package shsp_pkg;

	localparam logic [3:0]  PREFIX_LAST   = 4'd11;
	localparam logic [3:0]  IDX_MAGIC0    = 4'd0;
	localparam logic [3:0]  IDX_MAGIC1    = 4'd1;
	localparam logic [3:0]  IDX_VERSION   = 4'd2;
	localparam logic [3:0]  IDX_CODEC     = 4'd4;
	localparam logic [3:0]  IDX_CHANNELS  = 4'd5;
	localparam logic [3:0]  IDX_RATE_HI   = 4'd6;
	localparam logic [3:0]  IDX_RATE_LO   = 4'd7;
	localparam logic [3:0]  IDX_LEN_FIRST = 4'd8;
	localparam logic [3:0]  IDX_LEN_LAST  = 4'd11;

	localparam logic [7:0]  MAGIC0        = 8'h53;
	localparam logic [7:0]  MAGIC1        = 8'h48;
	localparam logic [7:0]  VERSION       = 8'd2;
	localparam logic [7:0]  CODEC         = 8'd0;
	localparam logic [7:0]  CHANNELS      = 8'd1;
	localparam logic [15:0] RATE          = 16'd8000;

	typedef enum logic [1:0] {
		PH_PREFIX   = 2'd0,
		PH_PAYLOAD  = 2'd1,
		PH_PCM      = 2'd2,
		PH_REJECTED = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EV_PCM      = 2'd0,
		EV_SKIPPED  = 2'd1,
		EV_RAW      = 2'd2,
		EV_REJECTED = 2'd3
	} event_t;

	typedef struct packed {
		phase_t phase;
		logic   payload_nz;
	} shsp_status_t;

endpackage

@@ hdl/stream_header_stripper_pcm.sv @@
// Top level of the stream header stripper for a 16-bit PCM byte stream.
// Depends on shsp_pkg, shsp_in_reg, shsp_core and the assertion header.
//
// One byte beat is accepted per clock unless the block stalls; an accepted byte passes
// the input register and the phase logic on its way to the result register.
// The block stalls only while a result beat waits unaccepted in the output register
// and a byte already sits in the input register. Write header_expected only while idle.
`include "stream_header_stripper_pcm_assert.svh"
module stream_header_stripper_pcm
	import shsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_kind,
	output logic signed [15:0] pcm_sample
);

	logic         take;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	shsp_status_t status;

	shsp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_byte(data_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	shsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_kind(event_kind),
		.pcm_sample(pcm_sample),
		.status    (status)
	);

	`SHSP_ASSERT_NEXT(a_reject_sticky, status.phase == PH_REJECTED, status.phase == PH_REJECTED, "rejected phase left before reset")
	`SHSP_ASSERT_NOW(a_payload_nz, status.phase == PH_PAYLOAD, status.payload_nz, "payload phase with zero bytes left")
	`SHSP_ASSERT_NOW(a_event_sample, out_valid && event_kind != EV_PCM, pcm_sample == 16'sd0, "nonzero sample on a header event")
	`SHSP_ASSERT_NOW(a_backpressure, valid_s1 && out_valid && !out_ready, !in_ready && !take, "byte taken while result beat is blocked")

endmodule

@@ hdl/shsp_in_reg.sv @@
// Input stage of the stream header stripper: holds one byte beat for the core.
// Depends on shsp_pkg.
module shsp_in_reg
	import shsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

@@ hdl/shsp_core.sv @@
// Core of the stream header stripper: phase machine, header checks, sample
// pairing and the result register. Depends on shsp_pkg.
module shsp_core
	import shsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              valid_s1,
	input  logic [7:0]        byte_s1,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        event_kind,
	output logic signed [15:0] pcm_sample,
	output shsp_status_t      status
);

	phase_t      phase_q, phase_d;
	logic        hdr_exp_q;
	logic [3:0]  count_q, count_d;
	logic        magic_ok_q, magic_ok_d;
	logic        fmt_ok_q, fmt_ok_d;
	logic [23:0] len_q, len_d;
	logic [30:0] left_q, left_d;
	logic [7:0]  low_q;
	logic        low_pend_q, low_pend_d;
	logic        emit;
	event_t      kind;
	logic [15:0] sample;
	logic        pcm_mode;
	logic [31:0] len_full;
	logic [30:0] len_eff;
	logic [30:0] left_dec;

	assign take      = valid_s1 && (!out_valid || out_ready);
	assign pcm_mode  = (phase_q == PH_PCM) || ((phase_q != PH_REJECTED) && !hdr_exp_q);
	assign len_full  = {len_q, byte_s1};
	assign len_eff   = len_full[31] ? 31'd0 : len_full[30:0];
	assign left_dec  = (left_q != 31'd0) ? left_q - 31'd1 : left_q;

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		magic_ok_d = magic_ok_q;
		fmt_ok_d   = fmt_ok_q;
		len_d      = len_q;
		left_d     = left_q;
		low_pend_d = low_pend_q;
		if (pcm_mode) begin
			low_pend_d = !low_pend_q;
		end else if (phase_q == PH_PREFIX) begin
			count_d = count_q + 4'd1;
			case (count_q)
				IDX_MAGIC0:   magic_ok_d = (byte_s1 == MAGIC0);
				IDX_MAGIC1:   magic_ok_d = magic_ok_q && (byte_s1 == MAGIC1);
				IDX_VERSION:  fmt_ok_d   = (byte_s1 == VERSION);
				IDX_CODEC:    fmt_ok_d   = fmt_ok_q && (byte_s1 == CODEC);
				IDX_CHANNELS: fmt_ok_d   = fmt_ok_q && (byte_s1 == CHANNELS);
				IDX_RATE_HI:  fmt_ok_d   = fmt_ok_q && (byte_s1 == RATE[15:8]);
				IDX_RATE_LO:  fmt_ok_d   = fmt_ok_q && (byte_s1 == RATE[7:0]);
				default:      ;
			endcase
			if (count_q >= IDX_LEN_FIRST && count_q <= IDX_LEN_LAST) begin
				len_d = {len_q[15:0], byte_s1};
			end
			if (count_q == PREFIX_LAST) begin
				if (!magic_ok_q) begin
					phase_d = PH_PCM;
				end else if (!fmt_ok_q) begin
					phase_d = PH_REJECTED;
				end else if (len_eff == 31'd0) begin
					phase_d = PH_PCM;
				end else begin
					left_d  = len_eff;
					phase_d = PH_PAYLOAD;
				end
			end
		end else if (phase_q == PH_PAYLOAD) begin
			left_d = left_dec;
			if (left_dec == 31'd0) begin
				phase_d = PH_PCM;
			end
		end
	end

	always_comb begin
		emit   = 1'b0;
		kind   = EV_PCM;
		sample = 16'd0;
		if (pcm_mode) begin
			emit   = low_pend_q;
			sample = {byte_s1, low_q};
		end else if (phase_q == PH_PREFIX) begin
			if (count_q == PREFIX_LAST) begin
				if (!magic_ok_q) begin
					emit = 1'b1;
					kind = EV_RAW;
				end else if (!fmt_ok_q) begin
					emit = 1'b1;
					kind = EV_REJECTED;
				end else if (len_eff == 31'd0) begin
					emit = 1'b1;
					kind = EV_SKIPPED;
				end
			end
		end else if (phase_q == PH_PAYLOAD) begin
			emit = (left_dec == 31'd0);
			kind = EV_SKIPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_exp_q  <= 1'b0;
			phase_q    <= PH_PREFIX;
			count_q    <= 4'd0;
			left_q     <= 31'd0;
			low_pend_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				hdr_exp_q <= cfg_wdata;
			end
			if (take) begin
				phase_q    <= phase_d;
				count_q    <= count_d;
				left_q     <= left_d;
				low_pend_q <= low_pend_d;
				out_valid  <= emit;
			end else if (out_ready) begin
				out_valid  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			magic_ok_q <= magic_ok_d;
			fmt_ok_q   <= fmt_ok_d;
			len_q      <= len_d;
			if (pcm_mode && !low_pend_q) begin
				low_q <= byte_s1;
			end
			if (emit) begin
				event_kind <= kind;
				pcm_sample <= sample;
			end
		end
	end

	assign status.phase      = phase_q;
	assign status.payload_nz = (left_q != 31'd0);

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stream_header_stripper_pcm: random bytes with idling and
// back-pressure are checked against a behavioral model of the header and sample logic.
// Depends on shsp_pkg and the stream_header_stripper_pcm RTL.
module testbench;
	import shsp_pkg::*;

	localparam int PREFIX_BYTES   = PREFIX_LAST + 1;
	localparam int SETTLE_CYCLES  = 8;
	localparam int QUIET_LIMIT    = 4000;
	localparam int LONG_HOLD      = 300;
	localparam logic [3:0] IDX_FLAGS = 4'd3;

	typedef enum int {
		HDR_EMPTY,
		HDR_PAYLOAD,
		HDR_LEN_TOPBIT,
		HDR_BAD_MAGIC,
		HDR_BAD_FORMAT
	} header_form_t;

	typedef struct packed {
		event_t             kind;
		logic signed [15:0] sample;
	} stripper_event_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_we     = 1'b0;
	logic               cfg_wdata  = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [7:0]         data_byte  = 8'd0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [1:0]         event_kind;
	logic signed [15:0] pcm_sample;

	stripper_event_t events_due[$];
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_request = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int mismatches   = 0;

	// Behavioral state of the stripper.
	logic       hdr_on;
	phase_t     strip_phase;
	int         prefix_fill;
	logic [7:0] prefix_seen [PREFIX_BYTES];
	logic [30:0] skip_left;
	logic [7:0] held_low;
	logic       low_held;

	stream_header_stripper_pcm u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.pcm_sample (pcm_sample)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic advance_stripper(input logic [7:0] b);
		logic [15:0] rate_w;
		logic [31:0] len_w;
		if (strip_phase == PH_REJECTED)
			return;
		if (strip_phase == PH_PCM || !hdr_on) begin
			if (!low_held) begin
				held_low = b;
				low_held = 1'b1;
			end else begin
				low_held = 1'b0;
				events_due.push_back('{EV_PCM, {b, held_low}});
			end
			return;
		end
		if (strip_phase == PH_PAYLOAD) begin
			if (skip_left != 0)
				skip_left--;
			if (skip_left == 0) begin
				strip_phase = PH_PCM;
				events_due.push_back('{EV_SKIPPED, 16'sd0});
			end
			return;
		end
		prefix_seen[prefix_fill] = b;
		prefix_fill++;
		if (prefix_fill < PREFIX_BYTES)
			return;
		rate_w = {prefix_seen[IDX_RATE_HI], prefix_seen[IDX_RATE_LO]};
		len_w = {prefix_seen[IDX_LEN_FIRST], prefix_seen[IDX_LEN_FIRST + 4'd1],
			prefix_seen[IDX_LEN_FIRST + 4'd2], prefix_seen[IDX_LEN_LAST]};
		if (prefix_seen[IDX_MAGIC0] != MAGIC0 || prefix_seen[IDX_MAGIC1] != MAGIC1) begin
			strip_phase = PH_PCM;
			events_due.push_back('{EV_RAW, 16'sd0});
		end else if (prefix_seen[IDX_VERSION] != VERSION || prefix_seen[IDX_CODEC] != CODEC
				|| prefix_seen[IDX_CHANNELS] != CHANNELS || rate_w != RATE) begin
			strip_phase = PH_REJECTED;
			events_due.push_back('{EV_REJECTED, 16'sd0});
		end else begin
			skip_left = len_w[31] ? 31'd0 : len_w[30:0];
			if (skip_left == 0) begin
				strip_phase = PH_PCM;
				events_due.push_back('{EV_SKIPPED, 16'sd0});
			end else begin
				strip_phase = PH_PAYLOAD;
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		advance_stripper(b);
	endtask

	// Stops sending, waits for every expected beat, then lets the pipeline empty.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_header_expected(input logic v);
		settle_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		hdr_on = v;
	endtask

	task automatic apply_reset();
		hdr_on = 1'b0;
		strip_phase = PH_PREFIX;
		prefix_fill = 0;
		skip_left = '0;
		held_low = 8'd0;
		low_held = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic test_pcm_extremes();
		logic [7:0] pattern [13];
		pattern = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00,
			8'h01, 8'h00, 8'h55, 8'hAA, 8'hC3};
		write_header_expected(1'b0);
		foreach (pattern[i])
			send_byte(pattern[i]);
		// The last low byte has to wait across the register write.
		write_header_expected(1'b0);
		send_byte(8'h3C);
	endtask

	task automatic test_random_pcm(input int count, input int send_pct, input int recv_pct);
		send_gap_pct = send_pct;
		recv_gap_pct = recv_pct;
		repeat (count)
			send_byte(8'($urandom));
	endtask

	task automatic test_backpressure();
		send_gap_pct = 0;
		hold_request = LONG_HOLD;
		repeat (60)
			send_byte(8'($urandom));
		settle_idle();
	endtask

	task automatic test_header_paths();
		logic [7:0]   hdr [PREFIX_BYTES];
		logic [31:0]  len_w;
		logic [7:0]   flip;
		header_form_t form;
		int split;
		int cut;
		int payload;
		form = header_form_t'($urandom_range(4));
		flip = 8'($urandom_range(255, 1));
		case (form)
			HDR_PAYLOAD:    len_w = $urandom_range(24, 1);
			HDR_LEN_TOPBIT: len_w = {1'b1, 31'($urandom)};
			HDR_EMPTY:      len_w = 32'd0;
			default:        len_w = $urandom;
		endcase
		hdr[IDX_MAGIC0]   = MAGIC0;
		hdr[IDX_MAGIC1]   = MAGIC1;
		hdr[IDX_VERSION]  = VERSION;
		hdr[IDX_FLAGS]    = 8'($urandom);
		hdr[IDX_CODEC]    = CODEC;
		hdr[IDX_CHANNELS] = CHANNELS;
		hdr[IDX_RATE_HI]  = RATE[15:8];
		hdr[IDX_RATE_LO]  = RATE[7:0];
		hdr[IDX_LEN_FIRST]        = len_w[31:24];
		hdr[IDX_LEN_FIRST + 4'd1] = len_w[23:16];
		hdr[IDX_LEN_FIRST + 4'd2] = len_w[15:8];
		hdr[IDX_LEN_LAST]         = len_w[7:0];
		if (form == HDR_BAD_MAGIC) begin
			case ($urandom_range(2))
				0: hdr[IDX_MAGIC0] ^= flip;
				1: hdr[IDX_MAGIC1] ^= flip;
				default: begin
					hdr[IDX_MAGIC0] ^= flip;
					hdr[IDX_MAGIC1] ^= 8'($urandom_range(255, 1));
				end
			endcase
		end else if (form == HDR_BAD_FORMAT) begin
			case ($urandom_range(4))
				0: hdr[IDX_VERSION]  ^= flip;
				1: hdr[IDX_CODEC]    ^= flip;
				2: hdr[IDX_CHANNELS] ^= flip;
				3: hdr[IDX_RATE_HI]  ^= flip;
				default: hdr[IDX_RATE_LO] ^= flip;
			endcase
		end

		// The prefix is interrupted by plain samples while the header is switched off.
		write_header_expected(1'b1);
		split = $urandom_range(PREFIX_BYTES - 1, 1);
		for (int i = 0; i < split; i++)
			send_byte(hdr[i]);
		write_header_expected(1'b0);
		repeat ($urandom_range(9, 2))
			send_byte(8'($urandom));
		write_header_expected(1'b1);
		for (int i = split; i < PREFIX_BYTES; i++)
			send_byte(hdr[i]);

		if (form == HDR_PAYLOAD) begin
			payload = int'(len_w);
			cut = (payload > 1) ? $urandom_range(payload - 1, 1) : 0;
			for (int i = 0; i < cut; i++)
				send_byte(8'($urandom));
			if (cut != 0) begin
				write_header_expected(1'b0);
				repeat ($urandom_range(9, 2))
					send_byte(8'($urandom));
				write_header_expected(1'b1);
			end
			for (int i = cut; i < payload; i++)
				send_byte(8'($urandom));
		end
		repeat (6)
			send_byte(8'($urandom));
		write_header_expected(1'b0);
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		stripper_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (events_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result beat: kind %0d sample %0d",
						event_kind, pcm_sample);
			end else begin
				want = events_due.pop_front();
				if (event_kind !== want.kind || pcm_sample !== want.sample) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected kind %0d sample %0d, got kind %0d sample %0d",
							want.kind, want.sample, event_kind, pcm_sample);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		apply_reset();
		test_pcm_extremes();
		test_random_pcm(220, 11, 72);
		test_backpressure();
		test_random_pcm(220, 72, 11);
		test_header_paths();
		test_random_pcm(200, 0, 0);
		settle_idle();
		if (mismatches == 0 && events_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/shsp_pkg.sv
hdl/shsp_in_reg.sv
hdl/shsp_core.sv
hdl/stream_header_stripper_pcm.sv
tb/testbench.sv
